@@ sv/cca_pkg.sv @@
// Package for the clover add-back block: sizes, constants, sequencer states.
// No dependencies.
package cca_pkg;
  localparam int unsigned MaxHitsDef    = 32;
  localparam int unsigned NumCloversDef = 8;
  localparam int unsigned StoreDepth    = 32;
  localparam int unsigned CrysPerClover = 4;
  localparam logic [31:0] GateLowRst    = 32'hFFFF_F600;
  localparam logic [31:0] GateHighRst   = 32'h0000_0A00;
  localparam logic [1:0]  RegGateLow    = 2'd0;
  localparam logic [1:0]  RegGateHigh   = 2'd1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_LEAD, ST_GATE, ST_OUT, ST_EMPTY
  } cca_state_e;
endpackage

@@ sv/clover_compton_addback.sv @@
// Clover add-back: collects one event's crystal hits, then sums them per clover.
// On the event's last word the block walks the store with one shared
// compare/subtract unit: per leader, a search pass and a gating pass over all
// stored hits (one hit per cycle each); every clover ends with one more search
// pass that finds nothing. Each result word waits until it is taken. Each
// result is held one step so the final one can carry last. The block is not
// ready from the event's last word until its final result word is accepted.
// Gate bounds are inclusive; time difference is (coarse diff)*256 + fine diff.
// Depends on cca_pkg.
module clover_compton_addback #(
  parameter int unsigned MAX_HITS    = cca_pkg::MaxHitsDef,
  parameter int unsigned NUM_CLOVERS = cca_pkg::NumCloversDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: crystal[4:0], hit_energy[28:5], coarse_time[76:29], fine_time[92:77], pad
  input  logic [95:0] s_axis_tdata_i,
  // tuser: hit_present
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: out_crystal[4:0], summed_energy[33:5], out_coarse[81:34],
  //        out_fine[97:82], pad
  output logic [103:0] m_axis_tdata_o,
  // tuser: empty_event
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import cca_pkg::*;

  localparam int unsigned Cap = (MAX_HITS < StoreDepth) ? MAX_HITS : StoreDepth;
  localparam int unsigned IW  = $clog2(StoreDepth);

  cca_state_e state_q, state_d;
  logic [31:0] gate_low_q, gate_high_q;

  // hit store (registers, each entry read through the walking index and the leader index)
  logic [4:0]  st_crys [StoreDepth];
  logic [23:0] st_en   [StoreDepth];
  logic [47:0] st_co   [StoreDepth];
  logic [15:0] st_fi   [StoreDepth];

  logic [IW:0]   cnt_q;
  logic [StoreDepth-1:0] used_q;
  logic [IW-1:0] idx_q;
  logic [3:0]    clov_q;
  logic          found_q, any_q;
  logic [IW-1:0] lead_q;
  logic [23:0]   lead_en_q;
  logic [28:0]   sum_q;
  logic          ovalid_q, olast_q, oempty_q;
  logic [4:0]    ocrys_q;
  logic [28:0]   osum_q;
  logic [47:0]   oco_q;
  logic [15:0]   ofi_q;
  logic          pend_q; // result built, waiting for next leader search to set last

  logic in_acc, out_acc, wr;
  logic [4:0]  in_crys;
  logic [23:0] in_en;
  logic [47:0] in_co;
  logic [15:0] in_fi;

  assign in_crys = s_axis_tdata_i[4:0];
  assign in_en   = s_axis_tdata_i[28:5];
  assign in_co   = s_axis_tdata_i[76:29];
  assign in_fi   = s_axis_tdata_i[92:77];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_LOAD) && !ovalid_q;

  assign pready_o = 1'b1;
  assign wr = psel_i && penable_i && pwrite_i;
  always_comb begin
    unique case (paddr_i[2])
      RegGateLow[0]:  prdata_o = gate_low_q;
      default:        prdata_o = gate_high_q;
    endcase
  end

  // shared walk unit: current entry qualifies for this clover
  logic        at_end, cand, in_gate;
  logic [63:0] td;
  assign at_end = ({1'b0, idx_q} == cnt_q - 1'b1) || (cnt_q == '0);
  assign cand = (cnt_q != '0) && !used_q[idx_q]
                && ({1'b0, st_crys[idx_q][4:2]} == clov_q);
  assign td = (({16'd0, st_co[idx_q]} - {16'd0, st_co[lead_q]}) << 8)
            + (64'(signed'(st_fi[idx_q])) - 64'(signed'(st_fi[lead_q])));
  assign in_gate = ($signed(td) >= 64'(signed'(gate_low_q)))
                && ($signed(td) <= 64'(signed'(gate_high_q)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && s_axis_tlast_i) state_d = ST_LEAD;
      ST_LEAD:  if (at_end) begin
        if (found_q || cand) state_d = ST_GATE;
        else if ({1'b0, clov_q} == 5'(NUM_CLOVERS - 1)) state_d = any_q ? ST_OUT : ST_EMPTY;
      end
      ST_GATE:  if (at_end) state_d = ST_OUT;
      ST_OUT: begin
        if (pend_q) begin
          if (out_acc || (!ovalid_q && !any_q)) state_d = ST_LEAD;
        end else if (!ovalid_q) begin
          state_d = ST_LOAD;
        end
      end
      ST_EMPTY: if (!ovalid_q) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i && cnt_q < (IW+1)'(Cap)) begin
      st_crys[cnt_q[IW-1:0]] <= in_crys;
      st_en[cnt_q[IW-1:0]]   <= in_en;
      st_co[cnt_q[IW-1:0]]   <= in_co;
      st_fi[cnt_q[IW-1:0]]   <= in_fi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; gate_low_q <= GateLowRst; gate_high_q <= GateHighRst;
      cnt_q <= '0; used_q <= '0; idx_q <= '0; clov_q <= '0; found_q <= 1'b0;
      any_q <= 1'b0; lead_q <= '0; lead_en_q <= '0; sum_q <= '0; pend_q <= 1'b0;
      ovalid_q <= 1'b0; olast_q <= 1'b0; oempty_q <= 1'b0;
      ocrys_q <= '0; osum_q <= '0; oco_q <= '0; ofi_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr && paddr_i[2] == RegGateLow[0])  gate_low_q  <= pwdata_i;
      if (wr && paddr_i[2] == RegGateHigh[0]) gate_high_q <= pwdata_i;
      if (out_acc) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: if (in_acc) begin
          if (s_axis_tuser_i && cnt_q < (IW+1)'(Cap)) cnt_q <= cnt_q + 1'b1;
          used_q <= '0; idx_q <= '0; clov_q <= '0; found_q <= 1'b0; any_q <= 1'b0;
        end
        ST_LEAD: begin
          if (cand && (!found_q || st_en[idx_q] > lead_en_q)) begin
            lead_q <= idx_q; lead_en_q <= st_en[idx_q]; found_q <= 1'b1;
          end
          idx_q <= at_end ? '0 : idx_q + 1'b1;
          if (at_end && !(found_q || cand)) begin
            clov_q <= clov_q + 1'b1;
            if (state_d == ST_OUT) begin
              // last search found nothing: flag the held result as last
              pend_q <= 1'b0;
            end
          end
          if (at_end && (found_q || cand)) begin
            if (cand && (!found_q || st_en[idx_q] > lead_en_q)) begin
              used_q[idx_q] <= 1'b1; sum_q <= 29'(st_en[idx_q]);
            end else begin
              used_q[lead_q] <= 1'b1; sum_q <= 29'(lead_en_q);
            end
          end
        end
        ST_GATE: begin
          if (cand && in_gate) begin
            used_q[idx_q] <= 1'b1; sum_q <= sum_q + 29'(st_en[idx_q]);
          end
          idx_q <= at_end ? '0 : idx_q + 1'b1;
          if (at_end) pend_q <= 1'b1;
        end
        ST_OUT: begin
          // results are held one step so the final one can carry last
          if (pend_q) begin
            if (out_acc || (!ovalid_q && !any_q)) begin
              // holding register is free: park the new result there
              any_q <= 1'b1; found_q <= 1'b0;
              ocrys_q <= st_crys[lead_q]; osum_q <= sum_q;
              oco_q <= st_co[lead_q]; ofi_q <= st_fi[lead_q]; oempty_q <= 1'b0;
            end else if (!ovalid_q) begin
              // a newer result exists, so the held one is not last
              ovalid_q <= 1'b1; olast_q <= 1'b0;
            end
          end else if (!ovalid_q) begin
            ovalid_q <= 1'b1; olast_q <= 1'b1; cnt_q <= '0;
          end
        end
        ST_EMPTY: if (!ovalid_q) begin
          ovalid_q <= 1'b1; olast_q <= 1'b1; oempty_q <= 1'b1; cnt_q <= '0;
          ocrys_q <= '0; osum_q <= '0; oco_q <= '0; ofi_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'd0, ofi_q, oco_q, osum_q, ocrys_q};
  assign m_axis_tuser_o  = oempty_q;
  assign m_axis_tlast_o  = olast_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == ST_LOAD) else $error("ready outside load");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o) else $error("empty not last");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (IW+1)'(Cap)) else $error("store overrun");
endmodule

@@ sim/tb.sv @@
// Testbench for clover_compton_addback: random and directed events, per-clover
// add-back predicted in a scoreboard class and checked word by word.
// Depends on cca_pkg and clover_compton_addback.
module tb;
  import cca_pkg::*;

  // Hit record as held by the predictor
  typedef struct packed {
    logic [4:0]  crystal;
    logic [23:0] energy;
    logic [47:0] coarse;
    logic [15:0] fine;
  } hit_t;

  // One summed output word
  typedef struct packed {
    logic [4:0]  crystal;
    logic [28:0] energy;
    logic [47:0] coarse;
    logic [15:0] fine;
    logic        empty;
    logic        last;
  } sum_t;

  // Scoreboard: mirrors the hit store and gate registers, predicts add-back
  class addback_sb;
    hit_t        hits[$];
    sum_t        pending[$];
    logic [31:0] gate_lo = GateLowRst;
    logic [31:0] gate_hi = GateHighRst;
    int          errors  = 0;

    function void set_gate(logic [1:0] idx, logic [31:0] val);
      if (idx == RegGateLow) gate_lo = val;
      else if (idx == RegGateHigh) gate_hi = val;
    endfunction

    // Called for every accepted input word
    function void note_hit(hit_t h, bit present, bit last);
      longint lo, hi, td;
      int      lead, n;
      logic [31:0] used;
      logic [28:0] acc;
      sum_t    s;
      bit      found;
      if (present && hits.size() < MaxHitsDef) hits.insert(hits.size(), h);
      if (!last) return;
      lo = longint'(signed'(gate_lo));
      hi = longint'(signed'(gate_hi));
      used = '0;
      n = 0;
      for (int c = 0; c < NumCloversDef; c++) begin
        forever begin
          found = 0;
          lead = 0;
          foreach (hits[i]) begin
            if (used[i] || (hits[i].crystal / CrysPerClover) != c) continue;
            if (!found || hits[i].energy > hits[lead].energy) begin
              lead = i;
              found = 1;
            end
          end
          if (!found) break;
          used[lead] = 1'b1;
          acc = 29'(hits[lead].energy);
          foreach (hits[i]) begin
            if (used[i] || (hits[i].crystal / CrysPerClover) != c) continue;
            td = (longint'({16'd0, hits[i].coarse}) - longint'({16'd0, hits[lead].coarse}))
                 * 256 + (longint'(signed'(hits[i].fine)) - longint'(signed'(hits[lead].fine)));
            if (td >= lo && td <= hi) begin
              acc += 29'(hits[i].energy);
              used[i] = 1'b1;
            end
          end
          s = '{hits[lead].crystal, acc, hits[lead].coarse, hits[lead].fine, 1'b0, 1'b0};
          pending.insert(pending.size(), s);
          n++;
        end
      end
      if (n == 0) begin
        s = '{5'd0, 29'd0, 48'd0, 16'd0, 1'b1, 1'b1};
        pending.insert(pending.size(), s);
      end else begin
        pending[pending.size()-1].last = 1'b1;
      end
      hits.delete();
    endfunction

    function void check_sum(sum_t got);
      sum_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.crystal !== want.crystal) begin
        $error("out_crystal exp %0d got %0d", want.crystal, got.crystal); errors++;
      end
      if (got.energy !== want.energy) begin
        $error("summed_energy exp %0d got %0d", want.energy, got.energy); errors++;
      end
      if (got.coarse !== want.coarse) begin
        $error("out_coarse exp %0d got %0d", want.coarse, got.coarse); errors++;
      end
      if (got.fine !== want.fine) begin
        $error("out_fine exp %0d got %0d", want.fine, got.fine); errors++;
      end
      if (got.empty !== want.empty) begin
        $error("empty_event exp %0d got %0d", want.empty, got.empty); errors++;
      end
      if (got.last !== want.last) begin
        $error("last_result exp %0d got %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [2:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  clover_compton_addback dut (.*);

  addback_sb sb = new();

  // Idle rates in percent, set per phase
  int  send_idle = 12;
  int  recv_idle = 76;
  bit  hold_off  = 1'b0;  // receiver holds tready low while set
  int  words_in  = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: tready changes on the falling edge, words sampled on the rising edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_sum({m_axis_tdata_o[4:0], m_axis_tdata_o[33:5], m_axis_tdata_o[81:34],
                    m_axis_tdata_o[97:82], m_axis_tuser_o, m_axis_tlast_o});
  end

  // APB write, setup then access phase; only called with the block idle
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel_i <= 1'b1; pwrite_i <= 1'b1; penable_i <= 1'b0;
    paddr_i <= {idx[0], 2'b00}; pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    sb.set_gate(idx, val);
    @(negedge clk_i);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
  endtask

  // Offer one word and hold it until accepted
  task automatic send_word(hit_t h, bit present, bit last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'd0, h.fine, h.coarse, h.energy, h.crystal};
    s_axis_tuser_i  <= present;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_hit(h, present, last);
    words_in++;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Wait for all results, then for the block to settle before a register write
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic hit_t rand_hit(bit clustered, logic [47:0] base);
    hit_t h;
    h.crystal = 5'($urandom_range(31));
    h.energy  = ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom);
    if (clustered) begin
      h.coarse = base + 48'($urandom_range(20));
      h.fine   = 16'($signed($urandom_range(1024)) - 512);
    end else begin
      h.coarse = {16'($urandom), 32'($urandom)};
      h.fine   = 16'($urandom);
    end
    return h;
  endfunction

  // Random event: mostly clustered hits in few clovers, some noise
  task automatic rand_event(int nmax);
    int          n;
    bit          clus;
    logic [47:0] base;
    hit_t        h;
    n    = $urandom_range(nmax);
    clus = $urandom_range(3) != 0;
    base = {16'($urandom), 32'($urandom)};
    for (int i = 0; i < n; i++) begin
      h = rand_hit(clus, base);
      if (clus && $urandom_range(1)) h.crystal[4:2] = 3'($urandom_range(1));
      send_word(h, 1'b1, i == n - 1);
    end
    if (n == 0) send_word(rand_hit(0, 0), 1'b0, 1'b1);
    else if ($urandom_range(7) == 0) send_word(rand_hit(0, 0), 1'b0, 1'b1);
  endtask

  initial begin
    hit_t h;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty event, all-ones and all-zero fields, equal energies, gate edges
    send_word('0, 1'b0, 1'b1);
    send_word('1, 1'b0, 1'b0);                         // ignored non-hit
    send_word('{5'd0, 24'd0, 48'd0, 16'd0}, 1'b1, 1'b0);
    send_word('{5'd31, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF}, 1'b1, 1'b1);
    send_word('{5'd1, 24'd100, 48'd1000, 16'h8000}, 1'b1, 1'b0);
    send_word('{5'd2, 24'd100, 48'd1000, 16'h7FFF}, 1'b1, 1'b0);
    send_word('{5'd3, 24'd50, 48'd1010, 16'd0}, 1'b1, 1'b0);   // coarse part of the diff is +2560
    send_word('{5'd0, 24'd40, 48'd990, 16'd0}, 1'b1, 1'b0);    // coarse part of the diff is -2560
    send_word('{5'd5, 24'hFFFFFF, 48'd7, 16'd0}, 1'b1, 1'b1);
    // Store overflow: 34 hits in clover 1, last two dropped
    for (int i = 0; i < 34; i++)
      send_word('{5'd4 + 5'(i % 4), 24'hFFFFFF, 48'd500, 16'(i)}, 1'b1, i == 33);
    drain();

    // Gate extremes: widest 32-bit window, then an empty one
    reg_write(RegGateLow, 32'h8000_0000);
    reg_write(RegGateHigh, 32'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) rand_event(8);
    drain();
    reg_write(RegGateLow, 32'd1);
    reg_write(RegGateHigh, 32'd0);
    for (int i = 0; i < 8; i++) rand_event(8);
    drain();
    reg_write(RegGateLow, GateLowRst);
    reg_write(RegGateHigh, GateHighRst);

    // Long receiver hold-off while events keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) rand_event(6);
    join
    drain();

    // Random phases with changing gates
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 76; recv_idle = 12; end
      if (ph == 2) begin send_idle = 0;  recv_idle = 0;  end
      reg_write(RegGateLow, -32'sd1 * 32'($urandom_range(5000)));
      reg_write(RegGateHigh, 32'($urandom_range(5000)));
      for (int i = 0; i < 30; i++) rand_event(($urandom_range(9) == 0) ? 32 : 6);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
